[rtl/mtg_pkg.sv]
// Package: shared types, constants and word functions of the MT19937 generator.
`default_nettype none

package mtg_pkg;

    // Pool geometry
    localparam int unsigned POOL_N = 624;
    localparam int unsigned POOL_M = 397;
    localparam int unsigned IDX_W  = 10;

    typedef logic [31:0]      t_word;
    typedef logic [IDX_W-1:0] t_idx;

    // Algorithm constants
    localparam t_word TWIST_MATRIX = 32'h9908_b0df;
    localparam t_word HIGH_BIT     = 32'h8000_0000;
    localparam t_word LOW_BITS     = 32'h7fff_ffff;
    localparam t_word INIT_MULT    = 32'd1812433253;
    localparam t_word DEFAULT_SEED = 32'd5489;
    localparam t_word TEMPER_B     = 32'h9d2c_5680;
    localparam t_word TEMPER_C     = 32'hefc6_0000;

    // Last index written by the initializer
    localparam t_idx IDX_LAST = IDX_W'(POOL_N - 1);
    localparam t_idx IDX_FIRST = IDX_W'(1);

    // Operation codes of an input item
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // What the tail of the chain takes in
    typedef enum logic [1:0] {
        FEED_SEED  = 2'd0,
        FEED_INIT  = 2'd1,
        FEED_TWIST = 2'd2
    } t_feed_sel;

    // Control from the sequencer to the chain and its feed unit
    typedef struct packed {
        logic      shift;
        t_feed_sel sel;
        t_word     seed;
        t_idx      idx;
    } t_feed_ctl;

    // One step of the linear initializer
    function automatic t_word init_next(input t_word prev, input t_idx idx);
        t_word x;
        t_word prod;
        x    = prev ^ (prev >> 30);
        prod = INIT_MULT * x;
        return prod + {{(32-IDX_W){1'b0}}, idx};
    endfunction

    // One twist step: combine the head, its neighbor and the far tap
    function automatic t_word mix_word(input t_word a, input t_word b, input t_word far);
        t_word y;
        y = (a & HIGH_BIT) | (b & LOW_BITS);
        return far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
    endfunction

    // Output tempering
    function automatic t_word temper(input t_word w);
        t_word y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

[rtl/mtg_if.sv]
// Interfaces: request channel (operation, seed) and response channel (random word).
`default_nettype none

interface mtg_req_if
    import mtg_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  operation;
    t_word seed_value;

    modport source (output valid, output operation, output seed_value, input ready);
    modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

interface mtg_rsp_if
    import mtg_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

[rtl/mtg_cell.sv]
// One cell of the state chain: holds a pool word and passes it on when the chain shifts.
`default_nettype none

module mtg_cell
    import mtg_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_shift,
    input  t_word i_din,
    output t_word o_dout
);

    t_word r_word;
    t_word n_word;

    // Take the neighbor's word on a shift, hold otherwise
    always_comb begin
        n_word = i_shift ? i_din : r_word;
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_dout = r_word;

endmodule

`default_nettype wire

[rtl/mtg_feed.sv]
// Feed unit at the tail of the chain: seed word, initializer step or twist step.
`default_nettype none

module mtg_feed
    import mtg_pkg::*;
(
    input  t_feed_ctl i_ctl,
    input  t_word     i_head,
    input  t_word     i_next,
    input  t_word     i_far,
    input  t_word     i_tail,
    output t_word     o_word
);

    // Select the word shifted in at the tail
    always_comb begin
        case (i_ctl.sel)
            FEED_SEED:  o_word = i_ctl.seed;
            FEED_INIT:  o_word = init_next(i_tail, i_ctl.idx);
            FEED_TWIST: o_word = mix_word(i_head, i_next, i_far);
            default:    o_word = i_ctl.seed;
        endcase
    end

endmodule

`default_nettype wire

[rtl/mersenne_twister_generator_top.sv]
// Top level: MT19937 generator built as a 624-cell shifting chain with a tail feed unit.
// Draw: tempered word is registered in the output register, or the skid slot if that is held.
// Throughput: one draw per cycle once seeded, while the skid slot is empty; each draw twists exactly one pool word.
// Reseed: request side busy while the pool fills, one initializer word per cycle through the tail multiplier.
// A draw before any seed is accepted, fills the pool from the default seed, then is served.
// Reset: synchronous, active low; clears control and output valid, pool is undefined.
`default_nettype none

module mersenne_twister_generator_top
    import mtg_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    mtg_req_if.sink    i_req,
    mtg_rsp_if.source  o_rsp
);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_FILL = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_seeded, n_seeded;
    logic   r_pend, n_pend;
    t_idx   r_fill_idx, n_fill_idx;
    logic   r_out_valid, n_out_valid;
    logic   r_sk_valid, n_sk_valid;
    t_word  r_out_word, n_out_word;
    t_word  r_sk_word, n_sk_word;

    t_feed_ctl feed_ctl;
    t_word     feed_word;
    t_word     tempered;
    t_word     chain [POOL_N];

    logic acc;
    logic pop;
    logic do_draw;
    logic fill_start;

    // Handshake
    assign i_req.ready = (r_state == ST_RUN) && !r_pend && !r_sk_valid;
    assign acc         = i_req.valid && i_req.ready;
    assign pop         = r_out_valid && o_rsp.ready;

    // Item decode
    assign fill_start = acc && ((i_req.operation == OP_RESEED) || !r_seeded);
    assign do_draw    = ((r_state == ST_RUN) && r_pend)
                     || (acc && (i_req.operation == OP_DRAW) && r_seeded);

    // Feed control
    always_comb begin
        feed_ctl.shift = do_draw || fill_start || (r_state == ST_FILL);
        feed_ctl.idx   = r_fill_idx;
        feed_ctl.seed  = (i_req.operation == OP_RESEED) ? i_req.seed_value : DEFAULT_SEED;
        if (fill_start) begin
            feed_ctl.sel = FEED_SEED;
        end else if (r_state == ST_FILL) begin
            feed_ctl.sel = FEED_INIT;
        end else begin
            feed_ctl.sel = FEED_TWIST;
        end
    end

    mtg_feed u_feed (
        .i_ctl  (feed_ctl),
        .i_head (chain[0]),
        .i_next (chain[1]),
        .i_far  (chain[POOL_M]),
        .i_tail (chain[POOL_N-1]),
        .o_word (feed_word)
    );

    // Chain of cells: cell k takes from cell k+1, the last one from the feed unit
    for (genvar k = 0; k < POOL_N; k++) begin : g_cell
        t_word din;
        if (k == POOL_N - 1) begin : g_tail
            assign din = feed_word;
        end else begin : g_body
            assign din = chain[k+1];
        end
        mtg_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (feed_ctl.shift),
            .i_din   (din),
            .o_dout  (chain[k])
        );
    end

    assign tempered = temper(feed_word);

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_seeded   = r_seeded;
        n_pend     = r_pend;
        n_fill_idx = r_fill_idx;
        case (r_state)
            ST_RUN: begin
                if (r_pend) begin
                    n_pend = 1'b0;
                end else if (fill_start) begin
                    n_state    = ST_FILL;
                    n_seeded   = 1'b1;
                    n_fill_idx = IDX_FIRST;
                    n_pend     = (i_req.operation == OP_DRAW);
                end
            end
            ST_FILL: begin
                n_fill_idx = r_fill_idx + IDX_FIRST;
                if (r_fill_idx == IDX_LAST) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    // Output register with skid slot
    always_comb begin
        n_out_valid = r_out_valid;
        n_sk_valid  = r_sk_valid;
        n_out_word  = r_out_word;
        n_sk_word   = r_sk_word;
        if (r_sk_valid) begin
            if (pop) begin
                n_out_word = r_sk_word;
                n_sk_valid = 1'b0;
            end
        end else if (do_draw) begin
            if (!r_out_valid || pop) begin
                n_out_word  = tempered;
                n_out_valid = 1'b1;
            end else begin
                n_sk_word  = tempered;
                n_sk_valid = 1'b1;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_seeded    <= 1'b0;
            r_pend      <= 1'b0;
            r_fill_idx  <= IDX_FIRST;
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seeded    <= n_seeded;
            r_pend      <= n_pend;
            r_fill_idx  <= n_fill_idx;
            r_out_valid <= n_out_valid;
            r_sk_valid  <= n_sk_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_sk_word  <= n_sk_word;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.random_word = r_out_word;

endmodule

`default_nettype wire

[rtl/mtg_checker.sv]
// Checker: port-level properties of the generator, bound to the top level.
`default_nettype none

module mtg_checker
    import mtg_pkg::*;
(
    input wire   i_clk,
    input wire   i_rst_n,
    input wire   i_req_valid,
    input wire   i_req_ready,
    input wire   i_req_operation,
    input wire   i_rsp_valid,
    input wire   i_rsp_ready,
    input t_word i_rsp_word
);

    logic req_acc;
    assign req_acc = i_req_valid && i_req_ready;

    // A stalled result holds its word
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_word))
        else $error("stalled result changed or dropped");

    // Reset empties the output side
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    // A reseed into an empty output produces no result
    a_seed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && (i_req_operation == OP_RESEED) && !i_rsp_valid |=> !i_rsp_valid)
        else $error("reseed produced a result");

    // A reseed keeps the request side busy while the pool fills
    a_seed_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && (i_req_operation == OP_RESEED) |=> !i_req_ready)
        else $error("item accepted during pool fill");

endmodule

bind mersenne_twister_generator_top mtg_checker u_mtg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_req_operation (i_req.operation),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_word      (o_rsp.random_word)
);

`default_nettype wire

[tb/sv/tb_mersenne_twister_generator_top.sv]
// Testbench: MT19937 generator checked item by item against a built-in predictor.
module tb_mersenne_twister_generator_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mtg_pkg::*;

    // Run control
    localparam int unsigned RANDOM_ITEMS    = 1400;
    localparam int unsigned DIRECTED_ROWS   = 22;
    localparam int unsigned PRESSURE_CYCLES = 320;
    localparam int unsigned DRAIN_CYCLES    = 700;
    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    localparam int unsigned MAX_PRINTED     = 50;

    // Position value that marks a generator that was never seeded
    localparam int unsigned UNSEEDED_POS = POOL_N + 1;

    // Standard output sequence for the default seed
    localparam t_word DEFAULT_WORD0 = 32'd3499211612;
    localparam t_word DEFAULT_WORD1 = 32'd581869302;

    typedef struct {
        logic  op;
        t_word seed;
        bit    has_lit;
        t_word lit;
    } t_stim_row;

    typedef struct {
        bit    has_lit;
        t_word lit;
    } t_word_note;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mtg_req_if req_if ();
    mtg_rsp_if rsp_if ();

    mersenne_twister_generator_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Predictor state
    t_word       pool_words [POOL_N];
    int unsigned read_pos = UNSEEDED_POS;

    // Expected words and per-item notes, both in acceptance order
    t_word       words_due [$];
    t_word_note  item_notes [$];
    int unsigned mismatches    = 0;
    int unsigned words_checked = 0;
    int unsigned idle_cycles   = 0;

    t_stim_row   directed_rows [DIRECTED_ROWS];

    // Clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Reset held low from the start, then released
    initial begin
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Linear initializer over the whole pool
    function automatic void pool_fill(input t_word s);
        t_word x;
        pool_words[0] = s;
        for (int unsigned i = 1; i < POOL_N; i++) begin
            x = pool_words[i-1] ^ (pool_words[i-1] >> 30);
            pool_words[i] = INIT_MULT * x + t_word'(i);
        end
        read_pos = POOL_N;
    endfunction

    // In-place regeneration, wrap-around taps see already updated words
    function automatic void pool_twist();
        int unsigned nb_idx;
        int unsigned far_idx;
        t_word       y;
        for (int unsigned k = 0; k < POOL_N; k++) begin
            nb_idx  = (k + 1) % POOL_N;
            far_idx = (k + POOL_M) % POOL_N;
            y = (pool_words[k] & HIGH_BIT) | (pool_words[nb_idx] & LOW_BITS);
            pool_words[k] = pool_words[far_idx] ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
        end
        read_pos = 0;
    endfunction

    function automatic t_word temper_word(input t_word w);
        t_word y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        return y ^ (y >> 18);
    endfunction

    // Next word of a draw; seeds with the default first if never seeded
    function automatic t_word mt_next_word();
        t_word w;
        if (read_pos >= POOL_N) begin
            if (read_pos == UNSEEDED_POS)
                pool_fill(DEFAULT_SEED);
            pool_twist();
        end
        w = pool_words[read_pos];
        read_pos++;
        return temper_word(w);
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        if (mismatches < MAX_PRINTED)
            $display("ERROR @%0t: %s got %08h want %08h", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one item and hold it until accepted
    task automatic offer(input logic op, input t_word seed, input bit quiet,
                         input bit has_lit, input t_word lit);
        int unsigned gap;
        t_word_note  note;
        gap = quiet ? 0 : idle_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        note.has_lit = has_lit;
        note.lit     = lit;
        item_notes.push_back(note);
        req_if.valid      <= 1'b1;
        req_if.operation  <= op;
        req_if.seed_value <= seed;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Monitor: check words, predict on accepted items, track activity
    always @(posedge i_clk) begin : monitor
        t_word      want;
        t_word_note note;
        bit         moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (rsp_if.valid && rsp_if.ready) begin
                moved = 1'b1;
                if (words_due.size() == 0) begin
                    report_mismatch("word with none due", rsp_if.random_word, '0);
                end else begin
                    want = words_due.pop_front();
                    if (rsp_if.random_word !== want)
                        report_mismatch("random_word", rsp_if.random_word, want);
                end
                words_checked++;
            end
            if (req_if.valid && req_if.ready) begin
                moved = 1'b1;
                note  = item_notes.pop_front();
                if (req_if.operation == OP_RESEED) begin
                    pool_fill(req_if.seed_value);
                end else begin
                    want = mt_next_word();
                    words_due.push_back(note.has_lit ? note.lit : want);
                end
            end
            if (moved)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Watchdog on cycles without any accepted item or taken word
    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random ready pattern plus one long hold-off
    initial begin : word_sink
        int unsigned low_left;
        int unsigned high_left;
        bit          pressure_done;
        logic        rdy;
        low_left      = 0;
        high_left     = 0;
        pressure_done = 1'b0;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!pressure_done && words_checked >= 400) begin
                pressure_done = 1'b1;
                low_left      = PRESSURE_CYCLES;
                high_left     = 0;
            end
            if (low_left == 0 && high_left == 0) begin
                low_left  = idle_gap();
                high_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
            end
            if (low_left > 0) begin
                rdy = 1'b0;
                low_left--;
            end else begin
                rdy = 1'b1;
                high_left--;
            end
            rsp_if.ready <= rdy;
        end
    end

    // Stimulus: directed table, then random items, then drain
    initial begin : stimulus
        logic  op;
        t_word seed;
        bit    quiet;
        req_if.valid      <= 1'b0;
        req_if.operation  <= OP_DRAW;
        req_if.seed_value <= '0;

        directed_rows = '{
            // draw before any seed: default seed sequence
            '{OP_DRAW,   32'h0000_0000, 1'b1, DEFAULT_WORD0},
            '{OP_DRAW,   32'hffff_ffff, 1'b1, DEFAULT_WORD1},
            '{OP_DRAW,   32'h0000_0000, 1'b0, '0},
            // seed extremes
            '{OP_RESEED, 32'h0000_0000, 1'b0, '0},
            '{OP_DRAW,   32'h0000_0000, 1'b0, '0},
            '{OP_DRAW,   32'h0000_0000, 1'b0, '0},
            '{OP_RESEED, 32'hffff_ffff, 1'b0, '0},
            '{OP_DRAW,   32'hffff_ffff, 1'b0, '0},
            '{OP_DRAW,   32'h0000_0000, 1'b0, '0},
            // explicit default seed restarts the known sequence
            '{OP_RESEED, DEFAULT_SEED,  1'b0, '0},
            '{OP_DRAW,   32'h0000_0000, 1'b1, DEFAULT_WORD0},
            '{OP_DRAW,   32'h0000_0000, 1'b1, DEFAULT_WORD1},
            // back-to-back reseeds, last one wins
            '{OP_RESEED, 32'h0000_0001, 1'b0, '0},
            '{OP_RESEED, 32'h8000_0000, 1'b0, '0},
            '{OP_DRAW,   32'h0000_0000, 1'b0, '0},
            '{OP_RESEED, 32'h5555_5555, 1'b0, '0},
            '{OP_DRAW,   32'hffff_ffff, 1'b0, '0},
            '{OP_RESEED, 32'haaaa_aaaa, 1'b0, '0},
            '{OP_DRAW,   32'h0000_0000, 1'b0, '0},
            '{OP_DRAW,   32'h5555_5555, 1'b0, '0},
            '{OP_RESEED, 32'h7fff_ffff, 1'b0, '0},
            '{OP_DRAW,   32'haaaa_aaaa, 1'b0, '0}
        };

        wait (i_rst_n);
        @(posedge i_clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].op, directed_rows[i].seed, 1'b0,
                  directed_rows[i].has_lit, directed_rows[i].lit);

        // Long draw runs first to cross pool boundaries, then frequent reseeds
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 300 && n < 600);
            if (n < 700)
                op = ($urandom_range(0, 499) == 0) ? OP_RESEED : OP_DRAW;
            else
                op = ($urandom_range(0, 39) == 0) ? OP_RESEED : OP_DRAW;
            case ($urandom_range(0, 19))
                0:       seed = 32'h0000_0000;
                1:       seed = 32'hffff_ffff;
                default: seed = $urandom();
            endcase
            offer(op, seed, quiet, 1'b0, '0);
        end
        req_if.valid <= 1'b0;

        while (words_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
rtl/mtg_pkg.sv
rtl/mtg_if.sv
rtl/mtg_cell.sv
rtl/mtg_feed.sv
rtl/mersenne_twister_generator_top.sv
rtl/mtg_checker.sv
tb/sv/tb_mersenne_twister_generator_top.sv
